FILE: design/kmrr_pkg.sv
// ----------------------------------------------------------------------------
// kmrr_pkg: shared types and constants of the key matrix rollover reporter
// Beat types of both channels, controller/datapath handshake structs and the
// controller state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmrr_pkg;

  // keycode slots carried in one report
  localparam int unsigned ReportSlots = 6;

  // keymap after reset: codes 4..9 for the six default keys
  localparam logic [63:0] KeymapReset = 64'h0000_0908_0706_0504;

  // one sampled column
  typedef struct packed {
    logic [1:0] column;
    logic [1:0] row_levels;
  } in_beat_t;

  // one report
  typedef struct packed {
    logic       key_row;
    logic [1:0] key_col;
    logic       pressed;
    logic [2:0] report_count;
    logic [7:0] slot_zero;
    logic [7:0] slot_one;
    logic [7:0] slot_two;
    logic [7:0] slot_three;
    logic [7:0] slot_four;
    logic [7:0] slot_five;
    logic       last;
  } out_beat_t;

  // controller states
  typedef enum logic [1:0] {
    StIdle,
    StRow,
    StFind,
    StSend
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input beat, start at row zero
    logic next_row;  // advance to the next row
    logic apply;     // update key level, fetch keycode, push on press
    logic step_ptr;  // advance the queue search pointer
    logic remove;    // drop the entry at the search pointer, close the gap
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic col_ok;      // column lies inside the matrix
    logic row_diff;    // current row level differs from stored state
    logic press;       // current row level is down
    logic last_row;    // current row is the bottom row
    logic search_end;  // search pointer has reached the queue length
    logic search_hit;  // entry at the search pointer equals the keycode
    logic last;        // no later row of this column changes
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: design/kmrr_dp.sv
// ----------------------------------------------------------------------------
// kmrr_dp: datapath of the key matrix rollover reporter
// Holds the keymap, key levels, held-key queue and the beat under work; does
// the keycode lookup, queue push, one-entry-per-cycle search and removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmrr_dp #(
  parameter int ROWS        = 2,
  parameter int COLS        = 3,
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [63:0]       cfg_wdata_i,
  input  wire kmrr_pkg::in_beat_t in_data_i,
  input  wire kmrr_pkg::dp_cmd_t cmd_i,
  output kmrr_pkg::dp_sts_t      sts_o,
  output kmrr_pkg::out_beat_t    out_data_o
);

  localparam int NK = ROWS * COLS;
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // stored level of the key at a flat index
  function automatic logic key_bit(input logic [NK-1:0] v, input logic [2:0] idx);
    logic b;
    b = 1'b0;
    for (int k = 0; k < NK; k++) begin
      if (3'(k) == idx) b = v[k];
    end
    return b;
  endfunction

  logic [63:0]   keymap_q;
  logic [NK-1:0] key_levels_q;
  logic [7:0]    queue_q [QUEUE_DEPTH];
  logic [CW-1:0] count_q;
  logic [CW-1:0] ptr_q;
  logic          row_q;
  logic [1:0]    col_q;
  logic [1:0]    levels_q;
  logic [7:0]    code_q;

  logic [2:0]    key_idx;
  logic [7:0]    code;
  logic          cur_level;
  logic          new_level;
  logic          later_diff;
  logic          full;
  logic          search_end;

  // key position and keycode lookup
  assign key_idx   = (row_q ? 3'(COLS) : 3'd0) + {1'b0, col_q};
  assign code      = keymap_q[{key_idx, 3'b000} +: 8];
  assign cur_level = key_bit(key_levels_q, key_idx);
  assign new_level = levels_q[row_q];
  assign full      = (count_q == CW'(QUEUE_DEPTH));
  assign search_end = (ptr_q >= count_q);

  // does any later row of this column still change
  always_comb begin
    later_diff = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      if (r > int'(row_q) &&
          levels_q[r] != key_bit(key_levels_q, 3'(r * COLS) + {1'b0, col_q})) begin
        later_diff = 1'b1;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts_o.col_ok     = ({1'b0, col_q} < 3'(COLS));
    sts_o.row_diff   = (cur_level != new_level);
    sts_o.press      = new_level;
    sts_o.last_row   = (int'(row_q) == ROWS - 1);
    sts_o.search_end = search_end;
    sts_o.search_hit = !search_end && (queue_q[ptr_q[IW-1:0]] == code_q);
    sts_o.last       = !later_diff;
  end

  // keymap, key levels, queue and walk pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keymap_q     <= kmrr_pkg::KeymapReset;
      key_levels_q <= '0;
      for (int j = 0; j < QUEUE_DEPTH; j++) queue_q[j] <= 8'd0;
      count_q      <= '0;
      ptr_q        <= '0;
      row_q        <= 1'b0;
    end else begin
      if (cfg_we_i) keymap_q <= cfg_wdata_i;
      if (cmd_i.load) row_q <= 1'b0;
      if (cmd_i.next_row) row_q <= row_q + 1'b1;
      if (cmd_i.step_ptr) ptr_q <= ptr_q + 1'b1;
      if (cmd_i.apply) begin
        ptr_q <= '0;
        for (int k = 0; k < NK; k++) begin
          if (3'(k) == key_idx) key_levels_q[k] <= new_level;
        end
        // press appends, a full queue drops the code
        if (new_level && !full) begin
          queue_q[count_q[IW-1:0]] <= code;
          count_q <= count_q + 1'b1;
        end
      end
      // release: shift later entries down one place, zero fills the top
      if (cmd_i.remove) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
          if (CW'(j) >= ptr_q) begin
            queue_q[j] <= (j == QUEUE_DEPTH - 1) ? 8'd0 : queue_q[(j + 1) % QUEUE_DEPTH];
          end
        end
        count_q <= count_q - 1'b1;
      end
    end
  end

  // beat under work
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q    <= in_data_i.column;
      levels_q <= in_data_i.row_levels;
    end
    if (cmd_i.apply) code_q <= code;
  end

  // report fields
  always_comb begin
    out_data_o.key_row      = row_q;
    out_data_o.key_col      = col_q;
    out_data_o.pressed      = new_level;
    out_data_o.report_count = (count_q > CW'(kmrr_pkg::ReportSlots)) ?
                              3'(kmrr_pkg::ReportSlots) : count_q[2:0];
    out_data_o.slot_zero    = (CW'(0) < count_q) ? queue_q[0] : 8'd0;
    out_data_o.slot_one     = (CW'(1) < count_q) ? queue_q[1] : 8'd0;
    out_data_o.slot_two     = (CW'(2) < count_q) ? queue_q[2] : 8'd0;
    out_data_o.slot_three   = (CW'(3) < count_q) ? queue_q[3] : 8'd0;
    out_data_o.slot_four    = (CW'(4) < count_q) ? queue_q[4] : 8'd0;
    out_data_o.slot_five    = (CW'(5) < count_q) ? queue_q[5] : 8'd0;
    out_data_o.last         = !later_diff;
  end

  // queue length never exceeds its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("held queue length above depth");

  // the top entry stays zero while the queue is not full
  a_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != CW'(QUEUE_DEPTH) |-> queue_q[QUEUE_DEPTH-1] == 8'd0)
    else $error("stale entry above queue length");

  // a removal shortens the queue by one
  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.remove |=> count_q == $past(count_q) - 1'b1)
    else $error("removal did not shorten queue");

endmodule

`default_nettype wire

FILE: design/kmrr_ctrl.sv
// ----------------------------------------------------------------------------
// kmrr_ctrl: controller of the key matrix rollover reporter
// Walks the rows of one column, sequences queue push, search and removal,
// and holds each report until the output side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmrr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire kmrr_pkg::dp_sts_t sts_i,
  output kmrr_pkg::dp_cmd_t      cmd_o
);

  kmrr_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmrr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kmrr_pkg::StIdle: begin
        if (in_valid_i) state_d = kmrr_pkg::StRow;
      end
      kmrr_pkg::StRow: begin
        if (!sts_i.col_ok) begin
          state_d = kmrr_pkg::StIdle;
        end else if (!sts_i.row_diff) begin
          if (sts_i.last_row) state_d = kmrr_pkg::StIdle;
        end else if (sts_i.press) begin
          state_d = kmrr_pkg::StSend;
        end else begin
          state_d = kmrr_pkg::StFind;
        end
      end
      kmrr_pkg::StFind: begin
        if (sts_i.search_end || sts_i.search_hit) state_d = kmrr_pkg::StSend;
      end
      kmrr_pkg::StSend: begin
        if (out_ready_i) state_d = sts_i.last ? kmrr_pkg::StIdle : kmrr_pkg::StRow;
      end
      default: state_d = kmrr_pkg::StIdle;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      kmrr_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      kmrr_pkg::StRow: begin
        if (sts_i.col_ok) begin
          if (sts_i.row_diff) cmd_o.apply = 1'b1;
          else if (!sts_i.last_row) cmd_o.next_row = 1'b1;
        end
      end
      kmrr_pkg::StFind: begin
        if (sts_i.search_hit) cmd_o.remove = 1'b1;
        else if (!sts_i.search_end) cmd_o.step_ptr = 1'b1;
      end
      kmrr_pkg::StSend: begin
        out_valid_o    = 1'b1;
        cmd_o.next_row = out_ready_i && !sts_i.last;
      end
      default: ;
    endcase
  end

  // one item at a time: never take a column while a report is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while report pending");

  // a taken report that is not the last leads back to the row walk
  a_more_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !sts_i.last |=> state_q == kmrr_pkg::StRow)
    else $error("row walk not resumed");

  // removal only ever issued during the search
  a_remove_in_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.remove |-> state_q == kmrr_pkg::StFind)
    else $error("removal outside search");

endmodule

`default_nettype wire

FILE: design/key_matrix_rollover_reporter.sv
// ----------------------------------------------------------------------------
// key_matrix_rollover_reporter: key matrix scanner with held-key reports
// Takes one sampled column, finds keys that changed, keeps an ordered queue
// of held keycodes and sends one report per changed key.
//
//   channel  direction  handshake                  beat
//   in       input      in_valid_i / in_ready_o    in_beat_t  (column, levels)
//   out      output     out_valid_o / out_ready_i  out_beat_t (one report)
//   cfg      input      cfg_we_i, no wait          64-bit keymap
//
// one column at a time: a column outside the matrix is dropped, rows without
// change are passed over one by one, a pressed key goes straight to its
// report, and a released key first searches the queue entry by entry (up to
// QUEUE_DEPTH entries) with the single-entry search compare
// a report holds until out_ready_i; no new column is taken meanwhile
// reset is immediate, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_rollover_reporter #(
  parameter int ROWS        = 2,
  parameter int COLS        = 3,
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire kmrr_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output kmrr_pkg::out_beat_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [63:0]         cfg_wdata_i
);

  kmrr_pkg::dp_cmd_t cmd;
  kmrr_pkg::dp_sts_t sts;

  // sequencing
  kmrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // state and queue
  kmrr_dp #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
